// ----- rtl/ltd_pkg.sv -----
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants for the lyric text deobfuscator: register
// indexes, character mapping constants and the beat formats between parts.
// ----------------------------------------------------------------------------
package ltd_pkg;

  // Configuration port geometry and register indexes.
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] RegCharOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyByte    = 1'b1;

  // Character mapping.
  localparam logic [6:0] CharBase  = 7'd65;
  localparam int         OffsetMod = 43;
  localparam logic [7:0] PlainLow  = 8'd32;

  // Queue of decoded units between the front and back parts.
  localparam int UnitQDepth = 4;
  localparam int UnitQPtrW  = $clog2(UnitQDepth);
  localparam int UnitQCntW  = $clog2(UnitQDepth + 1);

  // Output queue in front of the result ports.
  localparam int OutQDepth = 2;
  localparam int OutQPtrW  = $clog2(OutQDepth);
  localparam int OutQCntW  = $clog2(OutQDepth + 1);

  // One 13-bit code unit with its end-of-string and error marks.
  typedef struct packed {
    logic [12:0] unit;
    logic        last;
    logic        err;
  } unit_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_beat_t;

endpackage

// ----- rtl/ltd_unit_queue.sv -----
// ----------------------------------------------------------------------------
// ltd_unit_queue
// Short register queue of code units that decouples the character front
// from the UTF-8 back.
// ----------------------------------------------------------------------------
module ltd_unit_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ltd_pkg::unit_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ltd_pkg::unit_item_t item_o
);

  ltd_pkg::unit_item_t                  mem_q [ltd_pkg::UnitQDepth];
  logic [ltd_pkg::UnitQPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [ltd_pkg::UnitQPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [ltd_pkg::UnitQCntW-1:0]        cnt_q, cnt_d;
  logic                                 do_push, do_pop;

  assign full_o  = (cnt_q == ltd_pkg::UnitQCntW'(ltd_pkg::UnitQDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/ltd_front.sv -----
// ----------------------------------------------------------------------------
// ltd_front
// Holds the configuration, maps each character to a nibble, pairs nibbles
// into key-masked bytes and joins lead bytes into 13-bit code units.
// ----------------------------------------------------------------------------
module ltd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ltd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [7:0]                    text_char_i,
  input  logic                          end_of_text_i,
  output logic                          item_valid_o,
  output ltd_pkg::unit_item_t           item_o
);

  localparam logic [8:0] FoldBias = 9'd129;  // three times the modulus

  logic [5:0] offs_q;
  logic [7:0] key_q;

  logic       nib_wait_q, nib_wait_d;
  logic [3:0] high_nib_q, high_nib_d;
  logic       lead_wait_q, lead_wait_d;
  logic [4:0] lead_bits_q, lead_bits_d;
  logic       err_q, err_d;

  logic [8:0] fold;
  logic [5:0] offs_red;
  logic [6:0] shift;
  logic [8:0] diff;
  logic       in_range;
  logic [3:0] nib;
  logic       err_now;
  logic       have_byte;
  logic [7:0] byte_raw;
  logic [7:0] byte_key;
  logic       emit;

  // Offset modulo 43: 2^7 is -1 mod 43, so fold 7-bit digits with
  // alternating sign, then take off the remaining multiple of 43.
  always_comb begin
    fold = {2'b00, cfg_wdata_i[6:0]} + FoldBias + {7'd0, cfg_wdata_i[15:14]}
           - {2'b00, cfg_wdata_i[13:7]};
    offs_red = fold[5:0];
    for (int j = 1; j <= 6; j++) begin
      if (fold >= 9'(j * ltd_pkg::OffsetMod)) begin
        offs_red = 6'(fold - 9'(j * ltd_pkg::OffsetMod));
      end
    end
  end

  // Configuration registers; the offset is kept already reduced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
      key_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ltd_pkg::RegCharOffset: offs_q <= offs_red;
        ltd_pkg::RegKeyByte:    key_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Character to nibble; anything outside the sixteen codes flags an error.
  assign shift    = ltd_pkg::CharBase + {1'b0, offs_q};
  assign diff     = {1'b0, text_char_i} - {2'b00, shift};
  assign in_range = (text_char_i >= {1'b0, shift}) && (diff[7:4] == 4'd0);
  assign nib      = in_range ? diff[3:0] : 4'd0;
  assign err_now  = err_q || !in_range;

  // Byte assembly, high nibble first, zero padding at the end of a string.
  always_comb begin
    have_byte = 1'b0;
    byte_raw  = 8'd0;
    if (nib_wait_q) begin
      have_byte = 1'b1;
      byte_raw  = {high_nib_q, nib};
    end else if (end_of_text_i) begin
      have_byte = 1'b1;
      byte_raw  = {nib, 4'd0};
    end
  end

  assign byte_key = byte_raw ^ key_q;

  // A byte becomes a unit unless it is a lead waiting for its partner.
  assign emit = have_byte &&
                (lead_wait_q || !(byte_key < ltd_pkg::PlainLow && !end_of_text_i));

  assign item_valid_o = accept_i && emit;
  assign item_o.unit  = lead_wait_q ? {lead_bits_q, byte_key} : {5'd0, byte_key};
  assign item_o.last  = end_of_text_i;
  assign item_o.err   = err_now;

  // Pairing and lead state.
  always_comb begin
    nib_wait_d  = nib_wait_q;
    high_nib_d  = high_nib_q;
    lead_wait_d = lead_wait_q;
    lead_bits_d = lead_bits_q;
    err_d       = err_q;
    if (accept_i) begin
      err_d = err_now;
      if (nib_wait_q) begin
        nib_wait_d = 1'b0;
      end else if (!end_of_text_i) begin
        high_nib_d = nib;
        nib_wait_d = 1'b1;
      end
      if (have_byte) begin
        if (lead_wait_q) begin
          lead_wait_d = 1'b0;
        end else if (!emit) begin
          lead_bits_d = byte_key[4:0];
          lead_wait_d = 1'b1;
        end
      end
      // The end of a string returns everything to its reset value.
      if (end_of_text_i) begin
        nib_wait_d  = 1'b0;
        high_nib_d  = 4'd0;
        lead_wait_d = 1'b0;
        lead_bits_d = 5'd0;
        err_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_wait_q  <= 1'b0;
      high_nib_q  <= 4'd0;
      lead_wait_q <= 1'b0;
      lead_bits_q <= 5'd0;
      err_q       <= 1'b0;
    end else begin
      nib_wait_q  <= nib_wait_d;
      high_nib_q  <= high_nib_d;
      lead_wait_q <= lead_wait_d;
      lead_bits_q <= lead_bits_d;
      err_q       <= err_d;
    end
  end

endmodule

// ----- rtl/ltd_back.sv -----
// ----------------------------------------------------------------------------
// ltd_back
// Takes code units from the queue and sends each out as one to three UTF-8
// bytes, one byte per cycle while the output queue has room, through a two-entry output queue.
// ----------------------------------------------------------------------------
module ltd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                unit_empty_i,
  input  ltd_pkg::unit_item_t unit_i,
  output logic                unit_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ltd_pkg::out_beat_t  beat_o
);

  logic                         cur_valid_q, cur_valid_d;
  ltd_pkg::unit_item_t          cur_q;
  logic [1:0]                   idx_q, idx_d;

  ltd_pkg::out_beat_t           oq_q [ltd_pkg::OutQDepth];
  logic [ltd_pkg::OutQPtrW-1:0] oq_wr_q, oq_rd_q;
  logic [ltd_pkg::OutQCntW-1:0] oq_cnt_q, oq_cnt_d;
  logic                         oq_full;
  logic                         oq_push, oq_pop;

  logic [1:0]                   n_bytes;
  logic                         last_of_unit;
  logic                         take;
  ltd_pkg::out_beat_t           beat_new;

  // Length of the UTF-8 form of the current unit.
  always_comb begin
    if (cur_q.unit < 13'h0080) begin
      n_bytes = 2'd1;
    end else if (cur_q.unit < 13'h0800) begin
      n_bytes = 2'd2;
    end else begin
      n_bytes = 2'd3;
    end
  end

  assign last_of_unit = (idx_q == n_bytes - 2'd1);

  // Byte at the current position of the encoding.
  always_comb begin
    beat_new.data = cur_q.unit[7:0];
    case (n_bytes)
      2'd2: begin
        if (idx_q == 2'd0) begin
          beat_new.data = {3'b110, cur_q.unit[10:6]};
        end else begin
          beat_new.data = {2'b10, cur_q.unit[5:0]};
        end
      end
      2'd3: begin
        if (idx_q == 2'd0) begin
          beat_new.data = {7'b1110000, cur_q.unit[12]};
        end else if (idx_q == 2'd1) begin
          beat_new.data = {2'b10, cur_q.unit[11:6]};
        end else begin
          beat_new.data = {2'b10, cur_q.unit[5:0]};
        end
      end
      default: beat_new.data = {1'b0, cur_q.unit[6:0]};
    endcase
    beat_new.last = cur_q.last && last_of_unit;
    beat_new.err  = cur_q.err;
  end

  // Sequencing over the bytes of a unit; the next unit loads as the last
  // byte of this one leaves.
  assign oq_full    = (oq_cnt_q == ltd_pkg::OutQCntW'(ltd_pkg::OutQDepth));
  assign oq_push    = cur_valid_q && !oq_full;
  assign take       = !cur_valid_q || (oq_push && last_of_unit);
  assign unit_pop_o = take && !unit_empty_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (take) begin
      cur_valid_d = !unit_empty_i;
      idx_d       = 2'd0;
    end else if (oq_push) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (unit_pop_o) begin
      cur_q <= unit_i;
    end
  end

  // Output queue towards the result ports.
  assign empty_o = (oq_cnt_q == '0);
  assign oq_pop  = pop_i && !empty_o;
  assign beat_o  = oq_q[oq_rd_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= beat_new;
    end
  end

endmodule

// ----- rtl/lyric_text_deobfuscator.sv -----
// ----------------------------------------------------------------------------
// lyric_text_deobfuscator
// Decodes a stream of obfuscated characters into UTF-8 bytes.
// ----------------------------------------------------------------------------
// One character is taken per clock while full is low. The front part turns
// characters into 13-bit code units in the cycle of acceptance and writes them
// into a four-entry unit queue; full rises only when that queue is full. The
// back part emits one UTF-8 byte per clock while its output queue has room. A
// completed unit is written into the unit queue, then loaded into the current
// unit register, and its bytes go through the output queue. Inside a string two
// characters make a byte and a lead needs four for its unit, but the last
// character of a string completes a byte on its own, so runs of very short
// strings or of multi-byte units can ask for more than one byte per character.
// The unit queue then fills and full holds the input back until the back part
// catches up. Text that averages under one byte per character streams at one
// character per cycle while results are popped. bad_char stays set from a bad
// character to the end of its string.
// ----------------------------------------------------------------------------
module lyric_text_deobfuscator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ltd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ltd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    text_char_i,
  input  logic                          end_of_text_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    utf8_byte_o,
  output logic                          final_byte_o,
  output logic                          bad_char_o
);

  logic                accept;
  logic                unit_push;
  ltd_pkg::unit_item_t unit_in;
  ltd_pkg::unit_item_t unit_out;
  logic                unit_empty;
  logic                unit_pop;
  ltd_pkg::out_beat_t  beat;

  assign accept = push && !full;

  // Character front.
  ltd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .item_valid_o  (unit_push),
    .item_o        (unit_in)
  );

  // Unit queue between front and back.
  ltd_unit_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (unit_push),
    .item_i  (unit_in),
    .full_o  (full),
    .pop_i   (unit_pop),
    .empty_o (unit_empty),
    .item_o  (unit_out)
  );

  // UTF-8 back.
  ltd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .unit_empty_i (unit_empty),
    .unit_i       (unit_out),
    .unit_pop_o   (unit_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .beat_o       (beat)
  );

  assign utf8_byte_o  = beat.data;
  assign final_byte_o = beat.last;
  assign bad_char_o   = beat.err;

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lyric text deobfuscator. A scoreboard predicts
// the UTF-8 beats of every accepted character and checks each popped beat
// field by field. Both queue sides stall at random, and several register
// settings are used, the extremes among them.
// ----------------------------------------------------------------------------

// Predicts the decoded beats and holds them until the block delivers them.
class utf8_scoreboard;
  logic [15:0]        char_offset;
  logic [7:0]         key_byte;
  bit                 nibble_waiting;
  logic [3:0]         high_nibble;
  bit                 lead_waiting;
  logic [4:0]         lead_bits;
  bit                 error_seen;
  ltd_pkg::out_beat_t decoded_beats[$];
  int                 mismatches;
  int                 chars_seen;
  int                 strings_seen;
  int                 beats_seen;
  int                 wide_units;
  int                 bad_chars;

  function new();
    char_offset    = '0;
    key_byte       = '0;
    nibble_waiting = 1'b0;
    high_nibble    = '0;
    lead_waiting   = 1'b0;
    lead_bits      = '0;
    error_seen     = 1'b0;
    mismatches     = 0;
    chars_seen     = 0;
    strings_seen   = 0;
    beats_seen     = 0;
    wide_units     = 0;
    bad_chars      = 0;
  endfunction

  function void write_reg(logic [ltd_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    if (idx == ltd_pkg::RegCharOffset) begin
      char_offset = data;
    end else if (idx == ltd_pkg::RegKeyByte) begin
      key_byte = data[7:0];
    end
  endfunction

  // Code of the character that maps to nibble zero.
  function int char_shift();
    return int'(ltd_pkg::CharBase) + int'(char_offset) % ltd_pkg::OffsetMod;
  endfunction

  // Splits one code unit into its UTF-8 bytes.
  function void queue_unit(logic [12:0] code, bit eos);
    logic [7:0]         seq [3];
    int                 n;
    ltd_pkg::out_beat_t beat;
    if (code < 13'h80) begin
      seq[0] = code[7:0];
      n      = 1;
    end else if (code < 13'h800) begin
      seq[0] = 8'hC0 | 8'(code >> 6);
      seq[1] = 8'h80 | {2'b00, code[5:0]};
      n      = 2;
    end else begin
      seq[0] = 8'hE0 | {7'd0, code[12]};
      seq[1] = 8'h80 | {2'b00, code[11:6]};
      seq[2] = 8'h80 | {2'b00, code[5:0]};
      n      = 3;
      wide_units++;
    end
    for (int k = 0; k < n; k++) begin
      beat.data = seq[k];
      beat.last = eos && (k == n - 1);
      beat.err  = error_seen;
      decoded_beats.push_back(beat);
    end
  endfunction

  // Notes one accepted character and works out the beats it releases.
  function void note_char(logic [7:0] c, logic eos);
    int         diff;
    logic [3:0] nib;
    logic [7:0] assembled;
    bit         have;
    chars_seen++;
    diff = int'(c) - char_shift();
    if (diff >= 0 && diff <= 15) begin
      nib = diff[3:0];
    end else begin
      nib        = 4'h0;
      error_seen = 1'b1;
      bad_chars++;
    end
    have      = 1'b1;
    assembled = 8'h00;
    if (nibble_waiting) begin
      assembled      = {high_nibble, nib};
      nibble_waiting = 1'b0;
    end else if (eos) begin
      // An unpaired nibble at the end of the string is padded with zero.
      assembled = {nib, 4'h0};
    end else begin
      high_nibble    = nib;
      nibble_waiting = 1'b1;
      have           = 1'b0;
    end
    if (have) begin
      assembled = assembled ^ key_byte;
      if (lead_waiting) begin
        lead_waiting = 1'b0;
        queue_unit({lead_bits, assembled}, eos);
      end else if (assembled < ltd_pkg::PlainLow && !eos) begin
        lead_bits    = assembled[4:0];
        lead_waiting = 1'b1;
      end else begin
        queue_unit({5'd0, assembled}, eos);
      end
    end
    // Every string starts from a clean state; registers are kept.
    if (eos) begin
      nibble_waiting = 1'b0;
      high_nibble    = '0;
      lead_waiting   = 1'b0;
      lead_bits      = '0;
      error_seen     = 1'b0;
      strings_seen++;
    end
  endfunction

  function void check_beat(ltd_pkg::out_beat_t got);
    ltd_pkg::out_beat_t want;
    beats_seen++;
    if (decoded_beats.size() == 0) begin
      $error("unexpected beat: utf8_byte %02h", got.data);
      mismatches++;
      return;
    end
    want = decoded_beats.pop_front();
    if (got.data !== want.data) begin
      $error("utf8_byte: expected %02h, got %02h", want.data, got.data);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("final_byte: expected %0b, got %0b", want.last, got.last);
      mismatches++;
    end
    if (got.err !== want.err) begin
      $error("bad_char: expected %0b, got %0b", want.err, got.err);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return decoded_beats.size();
  endfunction
endclass

module tb_top;

  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 1000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ltd_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ltd_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         push;
  logic                         full;
  logic [7:0]                   text_char_i;
  logic                         end_of_text_i;
  logic                         empty;
  logic                         pop;
  logic [7:0]                   utf8_byte_o;
  logic                         final_byte_o;
  logic                         bad_char_o;

  bit             steady      = 1'b0;
  int             idle_cycles = 0;
  int             settings    = 0;
  utf8_scoreboard sb          = new();

  lyric_text_deobfuscator dut (.*);

  // Clock with a period of two units.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one; none in a steady phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly characters inside the nibble window, some just outside or anywhere.
  function automatic logic [7:0] pick_char();
    int r;
    int base;
    r    = $urandom_range(0, 99);
    base = sb.char_shift();
    if (r < 88) begin
      return 8'(base + $urandom_range(0, 15));
    end else if (r < 94) begin
      return 8'($urandom_range(0, 255));
    end else if (r < 97) begin
      return 8'(base - 1);
    end
    return 8'(base + 16);
  endfunction

  // Observe both handshakes at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_char(text_char_i, end_of_text_i);
      end
      if (pop && !empty) begin
        sb.check_beat('{data: utf8_byte_o, last: final_byte_o, err: bad_char_o});
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired with %0d beats outstanding.", sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: pop with random stalls between beats.
  initial begin
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Drives one character and holds it until the block takes it.
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    text_char_i   <= c;
    end_of_text_i <= eos;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i], i == txt.len() - 1);
    end
  endtask

  // Random strings until the character quota of a phase is used up.
  task automatic run_strings(input int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Lets the block drain, then writes both registers.
  task automatic load_settings(input logic [15:0] offset, input logic [7:0] key);
    logic [15:0] key_word;
    key_word = {8'($urandom), key};
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ltd_pkg::RegCharOffset;
    cfg_wdata_i <= offset;
    @(posedge clk_i);
    sb.write_reg(ltd_pkg::RegCharOffset, offset);
    cfg_idx_i   <= ltd_pkg::RegKeyByte;
    cfg_wdata_i <= key_word;
    @(posedge clk_i);
    sb.write_reg(ltd_pkg::RegKeyByte, key_word);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Main sequence.
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= ltd_pkg::RegCharOffset;
    cfg_wdata_i   <= '0;
    push          <= 1'b0;
    text_char_i   <= '0;
    end_of_text_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings with no shift and no key, so 'A' to 'P' are nibbles.
    load_settings(16'd0, 8'h00);
    send_text("PP");      // plain unit above 127
    send_text("BPPPCA");  // lead giving the largest unit, then a space
    send_text("AAHP");    // zero lead with 0x7F, ending on a paired unit
    send_text("EIG");     // odd trailing nibble
    send_text("BA");      // lead byte completed at the end stands alone
    send_text("ABI");     // lead waiting when an odd nibble ends the string
    // Characters below and above the window and at the field extremes.
    send_char(8'h40, 1'b0);
    send_char(8'h51, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h45, 1'b0);
    send_char(8'h41, 1'b1);
    send_text("P");       // error flag cleared for the next string
    run_strings(35);

    load_settings(16'd42, 8'hFF);
    run_strings(50);

    // No random gaps on either side in this phase.
    load_settings(16'hFFFF, 8'h5A);
    steady = 1'b1;
    run_strings(50);
    steady = 1'b0;

    load_settings(16'd43, 8'h1F);
    run_strings(50);

    for (int p = 0; p < 3; p++) begin
      load_settings(16'($urandom), 8'($urandom));
      run_strings(40);
    end

    // Wait for the last beats, then let the block settle.
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Decoded %0d characters in %0d strings under %0d register settings.",
             sb.chars_seen, sb.strings_seen, settings);
    $display("Checked %0d output bytes; %0d three-byte units, %0d characters out of range.",
             sb.beats_seen, sb.wide_units, sb.bad_chars);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ltd_pkg.sv
rtl/ltd_unit_queue.sv
rtl/ltd_front.sv
rtl/ltd_back.sv
rtl/lyric_text_deobfuscator.sv
verif/tb_top.sv
